/* src/stfsi_pkg.sv */
`timescale 1ns / 1ps

package stfsi_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ACT_W  = 2;

    localparam logic [ACT_W-1:0] ACT_SWAPPED    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FOUND_LAST = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INSERTED   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_FULL       = 2'd3;

    typedef struct packed {
        logic             load;
        logic             probe;
        logic             go_right;
        logic             go_left;
        logic             swap_rd;
        logic             swap_wr0;
        logic             swap_wr1;
        logic             shift_init;
        logic             shift_rd;
        logic             shift_wr;
        logic             ins_wr;
        logic             finish;
        logic [ACT_W-1:0] action;
    } cmd_t;

    typedef struct packed {
        logic search_open;
        logic is_full;
        logic hit;
        logic less;
        logic has_next;
        logic empty_gap;
        logic last_gap;
    } sts_t;

endpackage

/* src/stfsi_ctrl.sv */
`timescale 1ns / 1ps

module stfsi_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  stfsi_pkg::sts_t sts,
    output stfsi_pkg::cmd_t cmd
);
    import stfsi_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_SEARCH   = 10'b00_0000_0010,
        ST_COMPARE  = 10'b00_0000_0100,
        ST_SWAP_RD  = 10'b00_0000_1000,
        ST_SWAP_WR0 = 10'b00_0001_0000,
        ST_SWAP_WR1 = 10'b00_0010_0000,
        ST_SHIFT_RD = 10'b00_0100_0000,
        ST_SHIFT_WR = 10'b00_1000_0000,
        ST_INSERT   = 10'b01_0000_0000,
        ST_SPARE    = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (sts.search_open)
                begin
                    cmd.probe  = 1'b1;
                    state_next = ST_COMPARE;
                end
                else if (sts.is_full)
                begin
                    cmd.finish = 1'b1;
                    cmd.action = ACT_FULL;
                    state_next = ST_IDLE;
                end
                else if (sts.empty_gap)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = ST_SHIFT_RD;
                end
            end
            ST_COMPARE:
            begin
                if (sts.hit)
                begin
                    if (sts.has_next)
                    begin
                        state_next = ST_SWAP_RD;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        cmd.action = ACT_FOUND_LAST;
                        state_next = ST_IDLE;
                    end
                end
                else if (sts.less)
                begin
                    cmd.go_right = 1'b1;
                    state_next   = ST_SEARCH;
                end
                else
                begin
                    cmd.go_left = 1'b1;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SWAP_RD:
            begin
                cmd.swap_rd = 1'b1;
                state_next  = ST_SWAP_WR0;
            end
            ST_SWAP_WR0:
            begin
                cmd.swap_wr0 = 1'b1;
                state_next   = ST_SWAP_WR1;
            end
            ST_SWAP_WR1:
            begin
                cmd.swap_wr1 = 1'b1;
                cmd.finish   = 1'b1;
                cmd.action   = ACT_SWAPPED;
                state_next   = ST_IDLE;
            end
            ST_SHIFT_RD:
            begin
                cmd.shift_rd = 1'b1;
                state_next   = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                if (sts.last_gap)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_INSERT:
            begin
                cmd.ins_wr = 1'b1;
                cmd.finish = 1'b1;
                cmd.action = ACT_INSERTED;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle after a result");

    a_start_to_search: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == ST_IDLE) |=> state_reg == ST_SEARCH)
        else $error("accepted transfer did not start a search");

    a_full_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && !sts.search_open && sts.is_full)
        |-> (cmd.finish && cmd.action == ACT_FULL && !cmd.shift_init))
        else $error("miss on a full table was not reported as full");

endmodule

/* src/stfsi_dp.sv */
`timescale 1ns / 1ps

module stfsi_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [stfsi_pkg::DATA_W-1:0] value,
    input  stfsi_pkg::cmd_t                   cmd,
    output stfsi_pkg::sts_t                   sts,
    output logic                              done,
    output logic [stfsi_pkg::ACT_W-1:0]       action
);
    import stfsi_pkg::*;

    logic [DATA_W-1:0]        mem [DEPTH];

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0]        hold_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         lo_reg;
    logic [CNT_W-1:0]         hi1_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic [ADDR_W-1:0]        mid_reg;
    logic                     done_reg;
    logic [ACT_W-1:0]         action_reg;

    logic [CNT_W:0]           mid_sum;
    logic [ADDR_W-1:0]        mid;
    logic [CNT_W-1:0]         idx_prev;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [DATA_W-1:0]        wr_data;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi1_reg} - (CNT_W + 1)'(1);
    assign mid      = mid_sum[ADDR_W:1];
    assign idx_prev = idx_reg - CNT_W'(1);

    assign sts.search_open = (lo_reg < hi1_reg);
    assign sts.is_full     = (count_reg == CNT_W'(DEPTH));
    assign sts.hit         = (rdata_reg == value_reg);
    assign sts.less        = (rdata_reg < value_reg);
    assign sts.has_next    = ((CNT_W'(mid_reg) + CNT_W'(1)) < count_reg);
    assign sts.empty_gap   = (count_reg == lo_reg);
    assign sts.last_gap    = (idx_prev == lo_reg);

    always_comb
    begin
        rd_en   = cmd.probe | cmd.swap_rd | cmd.shift_rd;
        rd_addr = idx_prev[ADDR_W-1:0];
        if (cmd.probe)
        begin
            rd_addr = mid;
        end
        else if (cmd.swap_rd)
        begin
            rd_addr = mid_reg + ADDR_W'(1);
        end

        wr_en   = cmd.swap_wr0 | cmd.swap_wr1 | cmd.shift_wr | cmd.ins_wr;
        wr_addr = lo_reg[ADDR_W-1:0];
        wr_data = value_reg;
        if (cmd.swap_wr0)
        begin
            wr_addr = mid_reg;
            wr_data = rdata_reg;
        end
        else if (cmd.swap_wr1)
        begin
            wr_addr = mid_reg + ADDR_W'(1);
            wr_data = hold_reg;
        end
        else if (cmd.shift_wr)
        begin
            wr_addr = idx_reg[ADDR_W-1:0];
            wr_data = rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.swap_rd)
        begin
            hold_reg <= rdata_reg;
        end
        if (cmd.load)
        begin
            value_reg <= value;
        end
        if (cmd.probe)
        begin
            mid_reg <= mid;
        end
        if (cmd.finish)
        begin
            action_reg <= cmd.action;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            lo_reg    <= '0;
            hi1_reg   <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.load)
            begin
                lo_reg  <= '0;
                hi1_reg <= count_reg;
            end
            else if (cmd.go_right)
            begin
                lo_reg <= CNT_W'(mid_reg) + CNT_W'(1);
            end
            else if (cmd.go_left)
            begin
                hi1_reg <= CNT_W'(mid_reg);
            end
            if (cmd.shift_init)
            begin
                idx_reg <= count_reg;
            end
            else if (cmd.shift_wr)
            begin
                idx_reg <= idx_prev;
            end
            if (cmd.ins_wr)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    assign done   = done_reg;
    assign action = action_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds table depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_wr |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the entry count by one");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

endmodule

/* src/sorted_table_find_swap_or_insert_top.sv */
// Each probe reads one entry of the single-read memory. A hit on the last entry ends there,
// a hit elsewhere swaps the entry with its successor, and a miss on a full table is refused;
// any other miss moves any larger entries up one at a time and then writes the value.
// A new transfer is taken only while idle, at the earliest in the cycle done is high;
// the receiver cannot stall.
// Reset clears the entry count and the controller; table contents stay undefined.
`timescale 1ns / 1ps

module sorted_table_find_swap_or_insert_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [stfsi_pkg::DATA_W-1:0] value,
    output logic                                done,
    output logic [stfsi_pkg::ACT_W-1:0]         action
);
    import stfsi_pkg::*;

    cmd_t cmd;
    sts_t sts;

    stfsi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    stfsi_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (value),
        .cmd    (cmd),
        .sts    (sts),
        .done   (done),
        .action (action)
    );

endmodule

/* tb/stfsi_action_checker.sv */
`timescale 1ns / 1ps

module stfsi_action_checker
    import stfsi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     done,
    input  logic [ACT_W-1:0]         action,
    output int                       error_count,
    output int                       outstanding,
    output int                       swapped_seen,
    output int                       last_seen,
    output int                       inserted_seen,
    output int                       full_seen
);

    logic signed [DATA_W-1:0] table_words [DEPTH];
    int                       table_count;
    logic [ACT_W-1:0]         expected_actions [$];

    function automatic logic [ACT_W-1:0] find_swap_or_insert(
        input logic signed [DATA_W-1:0] v
    );
        int                       lo;
        int                       hi;
        int                       mid;
        int                       i;
        logic signed [DATA_W-1:0] held;
        lo = 0;
        hi = table_count - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (table_words[mid] == v)
            begin
                if (mid + 1 < table_count)
                begin
                    held = table_words[mid];
                    table_words[mid] = table_words[mid + 1];
                    table_words[mid + 1] = held;
                    return ACT_SWAPPED;
                end
                return ACT_FOUND_LAST;
            end
            if (table_words[mid] < v)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        if (table_count >= DEPTH)
            return ACT_FULL;
        for (i = table_count; i > lo; i--)
            table_words[i] = table_words[i - 1];
        table_words[lo] = v;
        table_count++;
        return ACT_INSERTED;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [ACT_W-1:0] want;
        if (!rst_n)
        begin
            table_count = 0;
            expected_actions.delete();
            error_count = 0;
            outstanding = 0;
            swapped_seen = 0;
            last_seen = 0;
            inserted_seen = 0;
            full_seen = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_actions.size() == 0)
                begin
                    $display("%0t: action %0d with no transfer pending, expected none",
                             $time, action);
                    error_count++;
                end
                else
                begin
                    want = expected_actions.pop_front();
                    outstanding--;
                    if (action !== want)
                    begin
                        $display("%0t: action mismatch, expected %0d actual %0d",
                                 $time, want, action);
                        error_count++;
                    end
                    case (want)
                        ACT_SWAPPED:    swapped_seen++;
                        ACT_FOUND_LAST: last_seen++;
                        ACT_INSERTED:   inserted_seen++;
                        default:        full_seen++;
                    endcase
                end
            end
            if (start && !busy)
            begin
                expected_actions.push_back(find_swap_or_insert(value));
                outstanding++;
            end
        end
    end

endmodule

/* tb/sorted_table_find_swap_or_insert_top_tb.sv */
`timescale 1ns / 1ps

module sorted_table_find_swap_or_insert_top_tb;
    import stfsi_pkg::*;

    localparam int RANDOM_ITEMS = 1900;
    localparam int DRAIN_CYCLES = 160;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] value;
    logic                     done;
    logic [ACT_W-1:0]         action;

    int error_count;
    int outstanding;
    int swapped_seen;
    int last_seen;
    int inserted_seen;
    int full_seen;
    int values_sent;
    bit gaps_on;

    logic signed [DATA_W-1:0] sent_values [$];

    sorted_table_find_swap_or_insert_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .value  (value),
        .done   (done),
        .action (action)
    );

    stfsi_action_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .value         (value),
        .done          (done),
        .action        (action),
        .error_count   (error_count),
        .outstanding   (outstanding),
        .swapped_seen  (swapped_seen),
        .last_seen     (last_seen),
        .inserted_seen (inserted_seen),
        .full_seen     (full_seen)
    );

    initial
        clk = 1'b0;

    always #10 clk = ~clk;

    task automatic send_value(input logic signed [DATA_W-1:0] v);
        if (gaps_on)
        begin
            while ($urandom_range(99) < 19)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (busy)
                    @(posedge clk);
            end
        end
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_values.push_back(v);
        values_sent++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int                       r;
        logic signed [DATA_W-1:0] v;
        r = $urandom_range(99);
        if (r < 45)
            v = sent_values[$urandom_range(sent_values.size() - 1)];
        else if (r < 60)
        begin
            v = sent_values[$urandom_range(sent_values.size() - 1)];
            v = $urandom_range(1) ? v + 1 : v - 1;
        end
        else if (r < 70)
        begin
            case ($urandom_range(4))
                0:       v = 32'sh8000_0000;
                1:       v = 32'sh7FFF_FFFF;
                2:       v = 32'sh0000_0000;
                3:       v = -32'sd1;
                default: v = 32'sd1;
            endcase
        end
        else
            v = $urandom;
        return v;
    endfunction

    initial
    begin
        #40_000_000;
        $display("sorted_table_find_swap_or_insert_top_tb: errors");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        values_sent = 0;
        gaps_on = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_value(32'sd0);
        send_value(32'sd0);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);
        send_value(-32'sd1);
        send_value(32'sd1);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);
        send_value(32'sh8000_0000);
        send_value(32'sh5555_5555);
        send_value(32'shAAAA_AAAA);
        send_value(32'sh7FFF_FFFE);
        send_value(32'sh8000_0001);
        send_value(-32'sd1);
        send_value(32'sd1);
        send_value(32'sh5555_5555);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_on = !(n >= 700 && n < 1100);
            send_value(pick_value());
        end
        start <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d values sent: %0d swapped, %0d found at the last entry,",
                 values_sent, swapped_seen, last_seen);
        $display("%0d inserted, %0d refused on a full table", inserted_seen, full_seen);
        if (error_count == 0)
            $display("sorted_table_find_swap_or_insert_top_tb: clean");
        else
            $display("sorted_table_find_swap_or_insert_top_tb: errors");
        $finish;
    end

endmodule
